>>> hdl/lagged_additive_random_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lagged additive random generator
// Clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LAGGED_ADDITIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define LAGGED_ADDITIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH

// A property that holds at every clock edge out of reset
`define LAGRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A same-cycle implication
`define LAGRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication
`define LAGRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lagrg_pkg.sv
// ----------------------------------------------------------------------------
// lagrg_pkg
// Shared constants, types and the default lag table for the generator.
// ----------------------------------------------------------------------------
package lagrg_pkg;

  localparam int TableDepth = 17;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int WordW      = 32;
  localparam int LagOffset  = 5;

  // seed fields: start index and silent step count
  localparam int SeedIdxMsb  = 3;
  localparam int SeedStepLsb = 8;
  localparam int SeedStepMsb = 12;
  localparam int StepCntW    = SeedStepMsb - SeedStepLsb + 1;

  typedef enum logic {
    CMD_PRODUCE = 1'b0,
    CMD_RESEED  = 1'b1
  } lagrg_cmd_t;

  // controller to datapath commands
  typedef struct packed {
    logic            fill_we;
    logic [IdxW-1:0] fill_addr;
    logic            seed_load;
    logic            rd_en;
    logic            step_en;
    logic            out_load;
  } lagrg_ctl_t;

  // default table contents loaded by every reseed
  function automatic logic [WordW-1:0] default_word(input int unsigned idx);
    logic [WordW-1:0] w;
    case (idx)
      0:       w = 32'd1571187604;
      1:       w = 32'd2130556662;
      2:       w = 32'd2075648113;
      3:       w = 32'd1384553414;
      4:       w = 32'd3758113950;
      5:       w = 32'd2350400989;
      6:       w = 32'd3768155391;
      7:       w = 32'd1438658665;
      8:       w = 32'd3424562190;
      9:       w = 32'd788898928;
      10:      w = 32'd107012447;
      11:      w = 32'd2497767687;
      12:      w = 32'd617416951;
      13:      w = 32'd3139554167;
      14:      w = 32'd2837196932;
      15:      w = 32'd224669655;
      16:      w = 32'd4159075602;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/lagrg_datapath.sv
// ----------------------------------------------------------------------------
// lagrg_datapath
// Lag table memory, running sum, table index and output data register.
// ----------------------------------------------------------------------------
module lagrg_datapath #(
  parameter int TABLE_DEPTH = lagrg_pkg::TableDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lagrg_pkg::lagrg_ctl_t         ctl,
  input  logic [lagrg_pkg::WordW-1:0]   seed,
  output logic [lagrg_pkg::WordW-1:0]   random_value
);

`include "lagged_additive_random_generator_core_assert.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int W     = lagrg_pkg::WordW;

  logic [W-1:0]     mem [TABLE_DEPTH];
  logic [W-1:0]     rd_a_r;
  logic [W-1:0]     rd_b_r;
  logic [W-1:0]     sum_r;
  logic [IDX_W-1:0] idx_r;
  logic [W-1:0]     out_data_r;

  logic [IDX_W-1:0] idx_i;
  logic [IDX_W:0]   j_raw;
  logic [IDX_W-1:0] idx_j;
  logic [IDX_W-1:0] idx_nxt;
  logic [W-1:0]     word;
  logic [W-1:0]     sum_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W-1:0]     wr_data;

  // lag addresses: i guarded against out of range, j = (i + lag) mod depth
  always_comb begin
    idx_i = (idx_r >= IDX_W'(TABLE_DEPTH)) ? '0 : idx_r;
    j_raw = {1'b0, idx_i} + (IDX_W+1)'(lagrg_pkg::LagOffset);
    if (j_raw >= (IDX_W+1)'(TABLE_DEPTH)) begin
      j_raw = j_raw - (IDX_W+1)'(TABLE_DEPTH);
    end
    idx_j   = j_raw[IDX_W-1:0];
    idx_nxt = (idx_i == '0) ? IDX_W'(TABLE_DEPTH - 1) : idx_i - 1'b1;
  end

  // step arithmetic on the registered table reads
  assign word    = rd_a_r + rd_b_r;
  assign sum_nxt = sum_r + word;

  // table write port: default fill or step writeback
  assign wr_en   = ctl.fill_we | ctl.step_en;
  assign wr_addr = ctl.fill_we ? ctl.fill_addr : idx_i;
  assign wr_data = ctl.fill_we ? lagrg_pkg::default_word(32'(ctl.fill_addr)) : word;

  // lag table memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_a_r <= mem[idx_i];
      rd_b_r <= mem[idx_j];
    end
  end

  // running sum and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (ctl.seed_load) begin
      sum_r <= W'(0) - seed;
      idx_r <= IDX_W'(seed[lagrg_pkg::SeedIdxMsb:0]);
    end else if (ctl.step_en) begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end

  // output data
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= sum_nxt;
    end
  end

  assign random_value = out_data_r;

  `LAGRG_ASSERT(a_idx_range, idx_r < IDX_W'(TABLE_DEPTH), "table index out of range")
  `LAGRG_ASSERT_NEXT(a_step_moves_idx, ctl.step_en && !ctl.seed_load,
                     idx_r != $past(idx_r), "step did not advance the index")

endmodule

>>> hdl/lagrg_ctrl.sv
// ----------------------------------------------------------------------------
// lagrg_ctrl
// Sequencer: input and output handshakes, default fill sweep, step count.
// ----------------------------------------------------------------------------
module lagrg_ctrl #(
  parameter int TABLE_DEPTH = lagrg_pkg::TableDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [lagrg_pkg::WordW-1:0]  in_seed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lagrg_pkg::lagrg_ctl_t        ctl
);

`include "lagged_additive_random_generator_core_assert.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = lagrg_pkg::StepCntW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_STEP
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] fill_cnt_r;
  logic [CNT_W-1:0] steps_left_r;
  logic             emit_r;
  logic             out_valid_r;

  logic in_xfer;
  logic is_reseed;
  logic out_free;
  logic out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign is_reseed = (in_command == lagrg_pkg::CMD_RESEED);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // datapath commands
  always_comb begin
    ctl.fill_we   = (state_r == ST_FILL);
    ctl.fill_addr = fill_cnt_r;
    ctl.seed_load = in_xfer && is_reseed;
    ctl.rd_en     = (state_r == ST_READ);
    ctl.step_en   = (state_r == ST_STEP) && (!emit_r || out_free);
    ctl.out_load  = (state_r == ST_STEP) && emit_r && out_free;
  end

  // result valid: set by a new result, cleared by an output transfer
  assign out_valid_nxt = ctl.out_load | (out_valid_r & ~out_ready);

  // state and registered outputs; reset runs a reseed with seed zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_cnt_r   <= '0;
      steps_left_r <= '0;
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (is_reseed) begin
              fill_cnt_r   <= '0;
              steps_left_r <= in_seed[lagrg_pkg::SeedStepMsb:lagrg_pkg::SeedStepLsb];
              emit_r       <= 1'b0;
              state_r      <= ST_FILL;
            end else begin
              emit_r  <= 1'b1;
              state_r <= ST_READ;
            end
          end
        end
        ST_FILL: begin
          if (fill_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= ST_READ;
          end else begin
            fill_cnt_r <= fill_cnt_r + 1'b1;
          end
        end
        ST_READ: begin
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          if (emit_r) begin
            if (out_free) begin
              state_r <= ST_IDLE;
            end
          end else if (steps_left_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            steps_left_r <= steps_left_r - 1'b1;
            state_r      <= ST_READ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `LAGRG_ASSERT_IMPL(a_no_overwrite, ctl.out_load, !out_valid_r || out_ready,
                     "pending result overwritten")
  `LAGRG_ASSERT_IMPL(a_one_writer, ctl.fill_we, !ctl.step_en,
                     "fill and step write the table together")
  `LAGRG_ASSERT_IMPL(a_rose_from_step, $rose(out_valid_r), $past(state_r) == ST_STEP,
                     "result appeared outside a produce step")

endmodule

>>> hdl/lagged_additive_random_generator_core.sv
// ----------------------------------------------------------------------------
// lagged_additive_random_generator_core
// 32-bit additive lagged generator, 17-word table, lag 5, running sum output.
// ----------------------------------------------------------------------------
// A produce command first reads table[i] and table[(i+5) mod 17] from the
// lag table memory, then adds, writes back and updates the sum; that step
// waits while an earlier result is still unaccepted. The next item is taken
// once the step is done, while the result may still wait in the output
// register. A reseed sweeps the default words into the table through the
// single memory write port, then runs (seed[12:8]) + 1 silent steps (1 to
// 32), each a read and a write. After reset the same sequence runs with
// seed zero before in_ready rises.
module lagged_additive_random_generator_core #(
  parameter int TABLE_DEPTH = lagrg_pkg::TableDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [lagrg_pkg::WordW-1:0]  in_seed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lagrg_pkg::WordW-1:0]  out_random_value
);

  lagrg_pkg::lagrg_ctl_t ctl;

  // sequencer
  lagrg_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_seed    (in_seed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctl        (ctl)
  );

  // table, sum and output data
  lagrg_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .seed         (in_seed),
    .random_value (out_random_value)
  );

endmodule

>>> dv/lagrg_tb_pkg.sv
// ----------------------------------------------------------------------------
// lagrg_tb_pkg
// Scoreboard for the lagged additive generator: keeps its own copy of the
// lag table, running sum and index, and checks each output transfer
// against the oldest predicted sum.
// ----------------------------------------------------------------------------
package lagrg_tb_pkg;

  import lagrg_pkg::*;

  // table contents restored by every reseed
  localparam logic [WordW-1:0] SEED_TABLE [TableDepth] = '{
    32'd1571187604, 32'd2130556662, 32'd2075648113, 32'd1384553414,
    32'd3758113950, 32'd2350400989, 32'd3768155391, 32'd1438658665,
    32'd3424562190, 32'd788898928,  32'd107012447,  32'd2497767687,
    32'd617416951,  32'd3139554167, 32'd2837196932, 32'd224669655,
    32'd4159075602
  };

  class lag_sum_scoreboard;
    logic [WordW-1:0] lag_words [TableDepth];
    logic [WordW-1:0] sum_acc;
    int unsigned      tap;
    logic [WordW-1:0] expected_sums [$];
    int unsigned      mismatches;
    int unsigned      sums_checked;

    function new();
      mismatches   = 0;
      sums_checked = 0;
      // out of reset the block looks as if reseeded with zero
      reload(32'd0);
    endfunction

    // one produce step: table[i] += table[i+5], sum += table[i], i--
    function logic [WordW-1:0] next_sum();
      int unsigned      lagged;
      logic [WordW-1:0] word;
      lagged = tap + LagOffset;
      if (lagged >= TableDepth) lagged -= TableDepth;
      word           = lag_words[tap] + lag_words[lagged];
      lag_words[tap] = word;
      sum_acc        = sum_acc + word;
      tap            = (tap == 0) ? TableDepth - 1 : tap - 1;
      return sum_acc;
    endfunction

    // default table, negated seed as sum, seed[3:0] as index, silent steps
    function void reload(logic [WordW-1:0] seed);
      int unsigned silent;
      lag_words = SEED_TABLE;
      sum_acc   = -seed;
      tap       = seed[SeedIdxMsb:0];
      silent    = seed[SeedStepMsb:SeedStepLsb] + 1;
      repeat (silent) void'(next_sum());
    endfunction

    // called for every accepted input transfer
    function void note_input(lagrg_cmd_t cmd, logic [WordW-1:0] seed);
      if (cmd == CMD_RESEED) reload(seed);
      else expected_sums.push_back(next_sum());
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    task report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
      mismatches++;
      $display("[%0t] MISMATCH %s: random_value got %h want %h", $time, what, got, want);
    endtask

    // called for every accepted output transfer
    task check_result(logic [WordW-1:0] got);
      logic [WordW-1:0] want;
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected output transfer", got, 'x);
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (got !== want) report_mismatch("wrong sum", got, want);
      end
    endtask

    task check_drained();
      while (expected_sums.size() != 0) begin
        report_mismatch("sum never delivered", 'x, expected_sums.pop_front());
      end
    endtask
  endclass

endpackage

>>> dv/lagged_additive_random_generator_core_tb.sv
// ----------------------------------------------------------------------------
// lagged_additive_random_generator_core_tb
// Drives produce and reseed commands into the generator through a short
// directed sequence and three random phases with different idle patterns
// on both channels, and checks every output sum against the scoreboard.
// ----------------------------------------------------------------------------
module lagged_additive_random_generator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lagrg_pkg::*;
  import lagrg_tb_pkg::*;

  localparam int RandomPerPhase = 640;
  localparam int ReseedPct      = 12;
  localparam int DrainCycles    = 100;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic             in_command = CMD_PRODUCE;
  logic [WordW-1:0] in_seed    = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [WordW-1:0] out_random_value;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  lag_sum_scoreboard sum_sb = new();

  lagged_additive_random_generator_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // output transfer monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sum_sb.check_result(out_random_value);
  end

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(lagrg_cmd_t cmd, logic [WordW-1:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_seed    <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sum_sb.note_input(cmd, seed);
  endtask

  task automatic send_random_item();
    logic [WordW-1:0] seed;
    seed = $urandom();
    if ($urandom_range(99) < ReseedPct) send_item(CMD_RESEED, seed);
    else send_item(CMD_PRODUCE, seed);
  endtask

  // sender goes idle, then waits for every expected sum
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sum_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, first phase's idle pattern
    send_idle_pct  = 14;
    recv_stall_pct = 79;
    // produce straight out of reset
    repeat (3) send_item(CMD_PRODUCE, 32'd0);
    // reseed with zero matches the reset state again
    send_item(CMD_RESEED, 32'd0);
    send_item(CMD_PRODUCE, 32'd0);
    // all ones: index 15, the most silent steps
    send_item(CMD_RESEED, 32'hFFFF_FFFF);
    send_item(CMD_PRODUCE, 32'hFFFF_FFFF);
    send_item(CMD_PRODUCE, 32'h0000_0000);
    // unused seed bits only reach the sum; index 0, one silent step
    send_item(CMD_RESEED, 32'hFFFF_E0F0);
    send_item(CMD_PRODUCE, 32'h0000_0000);
    // back-to-back reseeds, only the second counts
    send_item(CMD_RESEED, 32'h0000_0A05);
    send_item(CMD_RESEED, 32'h8000_1F00);
    send_item(CMD_PRODUCE, 32'h5555_5555);
    // long produce run wraps the index past zero
    repeat (12) send_item(CMD_PRODUCE, $urandom());

    // random phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        // hold the sender off until the pipe is empty
        if (phase == 0 && n == RandomPerPhase / 2) wait_drained();
        send_random_item();
      end
    end

    // let the last sums and any reseed in flight finish
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    sum_sb.check_drained();

    if (sum_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
